FILE: hw/rtl/assert_macros.svh
// Assertion macros shared by the checker files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, switched off while reset is asserted.
`define ESD_ASSERT_RST(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define ESD_ASSERT_ANY(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: hw/rtl/esd_pkg.sv
// Types and constants of the escape sequence decoder.
`default_nettype none

package esd_pkg;

    typedef struct packed {
        logic        func;
        logic [15:0] char_in;
    } t_in;

    typedef struct packed {
        logic [15:0] code_unit;
        logic        unit_valid;
        logic        last_of_run;
        logic        string_done;
    } t_out;

    // Results of one decoded item: count (0..2) and up to two result words.
    typedef struct packed {
        logic [1:0] n;
        t_out       r0;
        t_out       r1;
    } t_dec;

    localparam int RES_DEPTH = 4;
    localparam int RES_PTR_W = $clog2(RES_DEPTH);
    localparam int RES_CNT_W = $clog2(RES_DEPTH + 1);

    localparam logic [15:0] CH_BSLASH = 16'h005C;
    localparam logic [15:0] CH_QUOTE  = 16'h0022;
    localparam logic [15:0] CH_LF     = 16'h000A;
    localparam logic [15:0] CH_BS     = 16'h0008;
    localparam logic [15:0] CH_CR     = 16'h000D;
    localparam logic [15:0] CH_TAB    = 16'h0009;
    localparam logic [15:0] CH_N      = 16'h006E;
    localparam logic [15:0] CH_B      = 16'h0062;
    localparam logic [15:0] CH_R      = 16'h0072;
    localparam logic [15:0] CH_T      = 16'h0074;
    localparam logic [15:0] CH_X      = 16'h0078;
    localparam logic [15:0] CH_U_LO   = 16'h0075;
    localparam logic [15:0] CH_U_UP   = 16'h0055;
    localparam logic [15:0] CH_REPL   = 16'hFFFD;
    localparam logic [31:0] CP_MAX    = 32'h0010FFFF;
    localparam logic [5:0]  SUR_HI    = 6'b110110;
    localparam logic [5:0]  SUR_LO    = 6'b110111;

endpackage

`default_nettype wire

FILE: hw/rtl/esd_dec.sv
// Escape decode state and per-item result generation.
`default_nettype none

module esd_dec (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_go,
    input  esd_pkg::t_in  i_item,
    output esd_pkg::t_dec o_dec
);
    import esd_pkg::*;

    typedef enum logic [1:0] {
        MODE_NORMAL = 2'd0,
        MODE_ESC    = 2'd1,
        MODE_HEX    = 2'd2
    } t_mode;

    t_mode       r_mode, n_mode;
    logic [31:0] r_cp, n_cp;
    logic [3:0]  r_left, n_left;

    logic [15:0] c;
    logic        hex_ok;
    logic [3:0]  hex_d;
    logic [31:0] cp_new;
    logic [31:0] cp_sel;
    logic [3:0]  left_dec;
    logic        use_cp;
    logic        done;
    logic        one_res;
    logic [15:0] u0;
    logic        uv0;
    logic [20:0] cp_off;

    assign c = i_item.char_in;

    always_comb begin
        hex_ok = 1'b1;
        hex_d  = 4'd0;
        if (c >= 16'h0030 && c <= 16'h0039) begin
            hex_d = c[3:0];
        end else if ((c >= 16'h0041 && c <= 16'h0046) || (c >= 16'h0061 && c <= 16'h0066)) begin
            hex_d = c[3:0] + 4'd9;
        end else begin
            hex_ok = 1'b0;
        end
    end

    assign cp_new = {r_cp[27:0], hex_d};

    always_comb begin
        n_mode   = r_mode;
        n_cp     = r_cp;
        n_left   = r_left;
        use_cp   = 1'b0;
        cp_sel   = r_cp;
        done     = 1'b0;
        one_res  = 1'b0;
        u0       = '0;
        uv0      = 1'b1;
        left_dec = '0;
        if (i_item.func) begin
            n_mode = MODE_NORMAL;
            n_cp   = '0;
            n_left = '0;
            done   = 1'b1;
            if (r_mode == MODE_HEX) begin
                use_cp = 1'b1;
            end else begin
                one_res = 1'b1;
                uv0     = 1'b0;
            end
        end else begin
            unique case (r_mode)
                MODE_ESC: begin
                    n_mode = MODE_NORMAL;
                    unique case (c)
                        CH_N: begin one_res = 1'b1; u0 = CH_LF; end
                        CH_B: begin one_res = 1'b1; u0 = CH_BS; end
                        CH_R: begin one_res = 1'b1; u0 = CH_CR; end
                        CH_T: begin one_res = 1'b1; u0 = CH_TAB; end
                        CH_LF: ; // line continuation
                        CH_X: begin n_cp = '0; n_left = 4'd2; n_mode = MODE_HEX; end
                        CH_U_LO: begin n_cp = '0; n_left = 4'd4; n_mode = MODE_HEX; end
                        CH_U_UP: begin n_cp = '0; n_left = 4'd8; n_mode = MODE_HEX; end
                        default: begin one_res = 1'b1; u0 = c; end
                    endcase
                end
                MODE_HEX: begin
                    if (hex_ok) begin
                        n_cp     = cp_new;
                        left_dec = (r_left != 4'd0) ? r_left - 4'd1 : 4'd0;
                    end
                    n_left = left_dec;
                    if (left_dec == 4'd0) begin
                        n_mode = MODE_NORMAL;
                        use_cp = 1'b1;
                        cp_sel = hex_ok ? cp_new : r_cp;
                    end
                end
                default: begin
                    n_mode = MODE_NORMAL;
                    if (c == CH_BSLASH) begin
                        n_mode = MODE_ESC;
                    end else if (c != CH_QUOTE) begin
                        one_res = 1'b1;
                        u0      = c;
                    end
                end
            endcase
        end
    end

    assign cp_off = cp_sel[20:0] - 21'h010000;

    always_comb begin
        o_dec    = '0;
        o_dec.r0 = '{code_unit: u0, unit_valid: uv0, last_of_run: 1'b1, string_done: done};
        o_dec.n  = one_res ? 2'd1 : 2'd0;
        if (use_cp) begin
            o_dec.n = 2'd1;
            if (cp_sel > CP_MAX) begin
                o_dec.r0.code_unit = CH_REPL;
            end else if (cp_sel[31:16] == 16'd0) begin
                o_dec.r0.code_unit = cp_sel[15:0];
            end else begin
                o_dec.n  = 2'd2;
                o_dec.r0 = '{code_unit: {SUR_HI, cp_off[19:10]}, unit_valid: 1'b1,
                             last_of_run: 1'b0, string_done: done};
                o_dec.r1 = '{code_unit: {SUR_LO, cp_off[9:0]}, unit_valid: 1'b1,
                             last_of_run: 1'b1, string_done: done};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_NORMAL;
            r_cp   <= '0;
            r_left <= '0;
        end else if (i_go) begin
            r_mode <= n_mode;
            r_cp   <= n_cp;
            r_left <= n_left;
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/esd_fifo.sv
// Result queue: takes up to two results a cycle, hands out one per transfer.
`default_nettype none

module esd_fifo (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_push,
    input  esd_pkg::t_dec               i_dec,
    input  logic                        i_pop,
    output logic                        o_room2,
    output logic                        o_valid,
    output esd_pkg::t_out               o_data
);
    import esd_pkg::*;

    t_out                 r_q [RES_DEPTH];
    logic [RES_PTR_W-1:0] r_rd, n_rd;
    logic [RES_PTR_W-1:0] r_wr, n_wr;
    logic [RES_CNT_W-1:0] r_cnt, n_cnt;
    logic [RES_CNT_W-1:0] push_n;
    logic [RES_PTR_W-1:0] wr1;

    assign push_n  = i_push ? RES_CNT_W'(i_dec.n) : '0;
    assign wr1     = r_wr + RES_PTR_W'(1);
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_q[r_rd];
    assign o_room2 = (r_cnt <= RES_CNT_W'(RES_DEPTH - 2));

    always_comb begin
        n_rd  = r_rd + (i_pop ? RES_PTR_W'(1) : '0);
        n_wr  = r_wr + push_n[RES_PTR_W-1:0];
        n_cnt = r_cnt + push_n - (i_pop ? RES_CNT_W'(1) : '0);
    end

    always_ff @(posedge i_clk) begin
        if (i_push && i_dec.n != 2'd0) begin
            r_q[r_wr] <= i_dec.r0;
        end
        if (i_push && i_dec.n == 2'd2) begin
            r_q[wr1] <= i_dec.r1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd  <= '0;
            r_wr  <= '0;
            r_cnt <= '0;
        end else begin
            r_rd  <= n_rd;
            r_wr  <= n_wr;
            r_cnt <= n_cnt;
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/escape_sequence_decoder_unit.sv
// Top level of the backslash escape decoder producing UTF-16 code units.
//
//  channel | direction | valid       | stall       | payload
//  --------+-----------+-------------+-------------+--------------------
//  in      | to unit   | i_in_valid  | o_in_stall  | i_in_data  (t_in)
//  out     | from unit | o_out_valid | i_out_stall | o_out_data (t_out)
//
// One item per cycle enters the input register while o_in_stall is low; decode
// runs once the queue has room for two results and writes its 0, 1 or 2 results
// into a four-entry result queue. The queue drains one result per cycle while
// i_out_stall is low. o_in_stall comes from registers only: it is raised while
// the input register holds an item and the queue lacks room for two results.
// Synchronous active-low reset clears decode state and empties the queue.
`default_nettype none

module escape_sequence_decoder_unit (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  esd_pkg::t_in  i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output esd_pkg::t_out o_out_data
);
    import esd_pkg::*;

    logic r_in_valid, n_in_valid;
    t_in  r_in;
    t_dec dec;
    logic room2;
    logic go;
    logic in_xfer;

    assign go         = r_in_valid && room2;
    assign o_in_stall = r_in_valid && !room2;
    assign in_xfer    = i_in_valid && !o_in_stall;

    always_comb begin
        n_in_valid = r_in_valid;
        if (in_xfer) begin
            n_in_valid = 1'b1;
        end else if (go) begin
            n_in_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= n_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_in <= i_in_data;
        end
    end

    esd_dec u_dec (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (go),
        .i_item  (r_in),
        .o_dec   (dec)
    );

    esd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (go),
        .i_dec   (dec),
        .i_pop   (o_out_valid && !i_out_stall),
        .o_room2 (room2),
        .o_valid (o_out_valid),
        .o_data  (o_out_data)
    );

endmodule

`default_nettype wire

FILE: hw/rtl/esd_checker.sv
// Port-level checks for the escape decoder, bound to the top level.
`default_nettype none

`include "assert_macros.svh"

module esd_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          i_in_valid,
    input logic          o_in_stall,
    input esd_pkg::t_in  i_in_data,
    input logic          o_out_valid,
    input logic          i_out_stall,
    input esd_pkg::t_out o_out_data
);
    import esd_pkg::*;

    // a stalled input transfer keeps its payload until taken
    `ESD_ASSERT_RST(a_in_hold, i_clk, i_rst_n, i_in_valid && o_in_stall |=> i_in_valid && $stable(i_in_data), "stalled input changed")

    // a stalled result must not change
    `ESD_ASSERT_RST(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data), "stalled result changed")

    // only the high half of a surrogate pair is followed by more results
    `ESD_ASSERT_RST(a_first_is_high, i_clk, i_rst_n, o_out_valid && !o_out_data.last_of_run |-> o_out_data.unit_valid && o_out_data.code_unit[15:10] == SUR_HI, "non-final result is not a high surrogate")

    // an empty end marker stands alone and only answers end of string
    `ESD_ASSERT_RST(a_empty_marker, i_clk, i_rst_n, o_out_valid && !o_out_data.unit_valid |-> o_out_data.last_of_run && o_out_data.string_done && o_out_data.code_unit == 16'h0000, "malformed empty marker")

    // reset empties the result queue
    `ESD_ASSERT_ANY(a_reset_empty, i_clk, !i_rst_n |=> !o_out_valid, "result offered right after reset")

endmodule

bind escape_sequence_decoder_unit esd_checker u_esd_checker (.*);

`default_nettype wire
